@@ hdl/page_frame_replacement_assert.svh @@
// Assertion macros shared by the page frame replacement RTL.
`ifndef PAGE_FRAME_REPLACEMENT_ASSERT_SVH
`define PAGE_FRAME_REPLACEMENT_ASSERT_SVH
`ifndef SYNTHESIS
`define PFR_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("pfr: invariant violated");
`define PFR_ASSERT_NEXT(label, trig, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (expr)) \
    else $error("pfr: sequence violated");
`else
`define PFR_ASSERT_ALWAYS(label, expr)
`define PFR_ASSERT_NEXT(label, trig, expr)
`endif
`endif

@@ hdl/pfr_pkg.sv @@
// Types and constants of the page frame replacement block.
package pfr_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 8;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam int PageInW  = 8;
  localparam int SlotW    = 4;
  localparam int PageOutW = 8;
  localparam int FaultW   = 16;
  localparam int ModeW    = 2;
  localparam int FrCntW   = 5;

  localparam logic [ModeW-1:0]  POL_FIFO  = 2'd0;
  localparam logic [ModeW-1:0]  POL_LRU   = 2'd1;
  localparam logic [ModeW-1:0]  POL_CLOCK = 2'd2;

  localparam logic REG_POLICY_MODE   = 1'b0;
  localparam logic REG_FRAMES_IN_USE = 1'b1;

  localparam logic [FrCntW-1:0] FRAMES_RESET = 5'd16;
  localparam logic [FaultW-1:0] FAULT_MAX    = 16'hFFFF;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SEARCH = 8'b0000_0010,
    S_LRU    = 8'b0000_0100,
    S_CLOCK  = 8'b0000_1000,
    S_EVICT  = 8'b0001_0000,
    S_WRITE  = 8'b0010_0000,
    S_TOUCH  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } pfr_state_e;

  typedef struct packed {
    logic eq;
    logic lt;
  } pfr_cmp_t;

endpackage

@@ hdl/pfr_step_unit.sv @@
// Shared compare and hand-advance unit used by every scan of the frame table.
module pfr_step_unit import pfr_pkg::*; #(
  parameter int CmpW = 8,
  parameter int IdxW = 4,
  parameter int CntW = 5
) (
  input  logic [CmpW-1:0] op_a_i,
  input  logic [CmpW-1:0] op_b_i,
  input  logic [IdxW-1:0] wrap_in_i,
  input  logic [CntW-1:0] frames_i,
  output pfr_cmp_t        flags_o,
  output logic [IdxW-1:0] wrap_o
);

  logic [CntW-1:0] inc;

  assign flags_o.eq = (op_a_i == op_b_i);
  assign flags_o.lt = (op_a_i < op_b_i);

  // advance modulo the active frame count
  assign inc    = CntW'(wrap_in_i) + CntW'(1);
  assign wrap_o = (inc == frames_i) ? '0 : inc[IdxW-1:0];

endmodule

@@ hdl/page_frame_replacement.sv @@
// Page frame replacement top level: FIFO, LRU or CLOCK victim choice over a frame table.
// n is the active frame count. A search compares the page with each active frame; a miss
// fills the next empty frame or else evicts by FIFO, LRU or CLOCK, and the result is registered.
// One item at a time; the scans go one frame per cycle through the shared compare unit
// and the single read port of the page memory. The next item is taken once the result is
// registered. Reset at once clears valid and use bits, pointers and fault count, sets FIFO.
`include "page_frame_replacement_assert.svh"
module page_frame_replacement import pfr_pkg::*; #(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PageInW-1:0]  page_number_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                hit_o,
  output logic [SlotW-1:0]    frame_slot_o,
  output logic                evicted_valid_o,
  output logic [PageOutW-1:0] evicted_page_o,
  output logic [FaultW-1:0]   fault_total_o
);

  localparam int IdxW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CntW = $clog2(FRAMES + 1);
  localparam int RkW  = IdxW + 1;
  localparam int CmpW = (PAGE_BITS > RkW) ? PAGE_BITS : RkW;

  pfr_state_e state_q;

  logic [ModeW-1:0]     mode_q;
  logic [FrCntW-1:0]    frames_q;
  logic [CntW-1:0]      n_clamp;

  logic [PAGE_BITS-1:0] page_q;
  logic [CntW-1:0]      n_q;
  logic [CntW-1:0]      idx_q;
  logic [CntW-1:0]      nxt_idx;
  logic                 chk_q;
  logic [IdxW-1:0]      chk_idx_q;
  logic [IdxW-1:0]      slot_q;
  logic [IdxW-1:0]      best_q;
  logic [RkW-1:0]       best_rank_q;
  logic                 hit_q;
  logic                 evict_q;
  logic [PAGE_BITS-1:0] old_q;

  logic [PAGE_BITS-1:0] mem [FRAMES];
  logic [PAGE_BITS-1:0] rd_data_q;
  logic [IdxW-1:0]      rd_addr;
  logic [IdxW-1:0]      wr_addr;
  logic                 mem_we;

  logic [FRAMES-1:0]    valid_q;
  logic [FRAMES-1:0]    use_q;
  logic [IdxW-1:0]      rank_q [FRAMES];
  logic [IdxW-1:0]      rk_addr;
  logic [IdxW-1:0]      rank_rd;

  logic [CntW-1:0]      fill_q;
  logic [IdxW-1:0]      hand_q;
  logic [IdxW-1:0]      h_start;
  logic [FaultW-1:0]    fault_q;

  logic                 out_valid_q;
  logic                 out_hit_q;
  logic [SlotW-1:0]     out_slot_q;
  logic                 out_ev_q;
  logic [PageOutW-1:0]  out_evp_q;
  logic [FaultW-1:0]    out_fault_q;

  logic [CmpW-1:0]      op_a;
  logic [CmpW-1:0]      op_b;
  logic [IdxW-1:0]      wrap_in;
  logic [IdxW-1:0]      wrap_out;
  pfr_cmp_t             flags;

  logic                 in_acc;
  logic                 cfg_wr;
  logic                 issue;
  logic                 match;
  logic                 last_chk;
  logic                 miss_fill;
  logic                 lru_last;
  logic [IdxW-1:0]      idx_lo;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ? CfgDataW'(frames_q) : CfgDataW'(mode_q);

  always_comb begin
    if (frames_q == '0) begin
      n_clamp = CntW'(1);
    end else if (32'(frames_q) > 32'(FRAMES)) begin
      n_clamp = CntW'(FRAMES);
    end else begin
      n_clamp = CntW'(frames_q);
    end
  end

  // ---------------------------------------------------------------- datapath
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign idx_lo   = idx_q[IdxW-1:0];
  assign nxt_idx  = idx_q + CntW'(1);
  assign h_start  = (CntW'(hand_q) < n_q) ? hand_q : '0;
  assign rk_addr  = (state_q == S_TOUCH) ? slot_q : idx_lo;
  assign rank_rd  = rank_q[rk_addr];
  assign rd_addr  = (state_q == S_EVICT) ? slot_q : idx_lo;

  assign op_a    = (state_q == S_LRU) ? CmpW'(rank_rd) : CmpW'(rd_data_q);
  assign op_b    = (state_q == S_LRU) ? CmpW'(best_rank_q) : CmpW'(page_q);
  assign wrap_in = (state_q == S_CLOCK) ? idx_lo : h_start;

  pfr_step_unit #(
    .CmpW (CmpW),
    .IdxW (IdxW),
    .CntW (CntW)
  ) u_step (
    .op_a_i    (op_a),
    .op_b_i    (op_b),
    .wrap_in_i (wrap_in),
    .frames_i  (n_q),
    .flags_o   (flags),
    .wrap_o    (wrap_out)
  );

  assign issue     = (state_q == S_SEARCH) && (idx_q < n_q);
  assign match     = chk_q && valid_q[chk_idx_q] && flags.eq;
  assign last_chk  = chk_q && (CntW'(chk_idx_q) == n_q - CntW'(1));
  assign miss_fill = (state_q == S_SEARCH) && !match && last_chk && (fill_q < n_q);
  assign lru_last  = (idx_q == n_q - CntW'(1));

  assign mem_we  = miss_fill || (state_q == S_WRITE);
  assign wr_addr = (state_q == S_WRITE) ? slot_q : fill_q[IdxW-1:0];

  // page memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= page_q;
    end
    rd_data_q <= mem[rd_addr];
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= POL_FIFO;
      frames_q    <= FRAMES_RESET;
      valid_q     <= '0;
      use_q       <= '0;
      fill_q      <= '0;
      hand_q      <= '0;
      fault_q     <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_POLICY_MODE:   mode_q   <= pwdata[ModeW-1:0];
          REG_FRAMES_IN_USE: frames_q <= pwdata[FrCntW-1:0];
          default:           mode_q   <= mode_q;
        endcase
      end

      chk_q     <= issue;
      chk_idx_q <= idx_lo;

      // drop a taken beat unless a new one is loaded this cycle
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            page_q  <= PAGE_BITS'(page_number_i);
            n_q     <= n_clamp;
            idx_q   <= '0;
            state_q <= S_SEARCH;
          end
        end

        S_SEARCH: begin
          if (issue) begin
            idx_q <= nxt_idx;
          end
          if (match) begin
            hit_q   <= 1'b1;
            evict_q <= 1'b0;
            old_q   <= '0;
            slot_q  <= chk_idx_q;
            state_q <= S_TOUCH;
          end else if (last_chk) begin
            hit_q <= 1'b0;
            if (fill_q < n_q) begin
              // empty frame left: fill in order, no eviction
              slot_q                     <= fill_q[IdxW-1:0];
              valid_q[fill_q[IdxW-1:0]]  <= 1'b1;
              use_q[fill_q[IdxW-1:0]]    <= 1'b1;
              rank_q[fill_q[IdxW-1:0]]   <= fill_q[IdxW-1:0];
              fill_q                     <= fill_q + CntW'(1);
              evict_q                    <= 1'b0;
              old_q                      <= '0;
              state_q                    <= S_DONE;
            end else begin
              evict_q <= 1'b1;
              case (mode_q)
                POL_LRU: begin
                  idx_q       <= '0;
                  best_q      <= '0;
                  best_rank_q <= '1;
                  state_q     <= S_LRU;
                end
                POL_CLOCK: begin
                  idx_q   <= CntW'(h_start);
                  state_q <= S_CLOCK;
                end
                default: begin
                  slot_q  <= h_start;
                  hand_q  <= wrap_out;
                  state_q <= S_EVICT;
                end
              endcase
            end
          end
        end

        S_LRU: begin
          // keep the first frame holding the lowest rank
          if (flags.lt) begin
            best_q      <= idx_lo;
            best_rank_q <= RkW'(rank_rd);
          end
          if (lru_last) begin
            slot_q  <= flags.lt ? idx_lo : best_q;
            state_q <= S_EVICT;
          end else begin
            idx_q <= nxt_idx;
          end
        end

        S_CLOCK: begin
          if (!use_q[idx_lo]) begin
            slot_q  <= idx_lo;
            hand_q  <= wrap_out;
            state_q <= S_EVICT;
          end else begin
            use_q[idx_lo] <= 1'b0;
            idx_q         <= CntW'(wrap_out);
          end
        end

        S_EVICT: begin
          state_q <= S_WRITE;
        end

        S_WRITE: begin
          old_q   <= rd_data_q;
          state_q <= S_TOUCH;
        end

        S_TOUCH: begin
          // close the gap left by the touched frame, then make it most recent
          for (int j = 0; j < FRAMES; j++) begin
            if ((IdxW'(j) != slot_q) && valid_q[j] && (rank_q[j] > rank_rd)) begin
              rank_q[j] <= rank_q[j] - IdxW'(1);
            end
          end
          rank_q[slot_q] <= IdxW'(fill_q - CntW'(1));
          use_q[slot_q]  <= 1'b1;
          if (evict_q && (fault_q != FAULT_MAX)) begin
            fault_q <= fault_q + FaultW'(1);
          end
          state_q <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= hit_q;
            out_slot_q  <= SlotW'(slot_q);
            out_ev_q    <= evict_q;
            out_evp_q   <= PageOutW'(old_q);
            out_fault_q <= fault_q;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign frame_slot_o    = out_slot_q;
  assign evicted_valid_o = out_ev_q;
  assign evicted_page_o  = out_evp_q;
  assign fault_total_o   = out_fault_q;

  // ---------------------------------------------------------------- checks
  `PFR_ASSERT_NEXT(a_accept_search, in_acc, state_q == S_SEARCH)
  `PFR_ASSERT_ALWAYS(a_fill_bound, 32'(fill_q) <= 32'(FRAMES))
  `PFR_ASSERT_ALWAYS(a_touch_valid, (state_q != S_TOUCH) || valid_q[slot_q])
  `PFR_ASSERT_NEXT(a_fault_mono, 1'b1, fault_q >= $past(fault_q))
  `PFR_ASSERT_ALWAYS(a_hit_no_evict, !out_valid_o || !(hit_o && evicted_valid_o))

endmodule
